// ----- design/sm3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, types and round helper functions for the SM3 engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;

	localparam logic [31:0] IV [8] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} state_t;

	// Control from the sequencer to the compression core.
	typedef struct packed {
		logic start;
		logic [5:0] round;
		logic fold;
	} core_ctrl_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ----- design/sm3_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 compression core
// One round per cycle with a 16-word sliding expansion window.
// ----------------------------------------------------------------------------
module sm3_core import sm3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  core_ctrl_t       ctrl,
	input  logic             iv_load,
	input  logic [31:0]      blk [16],
	output logic [31:0]      cv [8]
);

	logic [31:0] cv_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
	logic hi;

	assign hi = ctrl.round[5] | ctrl.round[4];
	assign tj = rotl(hi ? T_HIGH : T_LOW, ctrl.round[4:0]);
	assign a12 = rotl(v_q[0], 5'd12);
	assign ss1 = rotl(a12 + v_q[4] + tj, 5'd7);
	assign ss2 = ss1 ^ a12;
	assign ff = hi ? ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]))
		: (v_q[0] ^ v_q[1] ^ v_q[2]);
	assign gg = hi ? ((v_q[4] & v_q[5]) | ((v_q[4] ^ ALL_ONES) & v_q[6]))
		: (v_q[4] ^ v_q[5] ^ v_q[6]);
	assign tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
	assign tt2 = gg + v_q[7] + ss1 + w_q[0];
	assign wn = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
		end else if (iv_load) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
		end else if (ctrl.fold) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
		end else begin
			v_q[0] <= tt1;
			v_q[1] <= v_q[0];
			v_q[2] <= rotl(v_q[1], 5'd9);
			v_q[3] <= v_q[2];
			v_q[4] <= perm0(tt2);
			v_q[5] <= v_q[4];
			v_q[6] <= rotl(v_q[5], 5'd19);
			v_q[7] <= v_q[6];
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

	assign cv = cv_q;

endmodule

// ----- design/sm3_hash_engine_top.sv -----
`timescale 1ns / 1ps
// A word that does not fill a block is accepted without holding the input.
// A word completing a 64-byte block holds the input through load, 64 rounds and fold.
// A final word pads a byte per cycle, compressing each full block, then emits eight beats.
// A single round unit serves every block; no new word is taken while one is compressed.
// Reset returns the chaining value to the IV and clears counts and control.
// ----------------------------------------------------------------------------
// SM3 hash engine top
// Byte packing, padding sequencer and digest output around the round core.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t state_q, state_d;
	logic [31:0] buf_q [16];
	logic [31:0] buf_d [16];
	logic [31:0] spill_q, spill_d;
	logic [6:0]  pos;
	logic [5:0]  fill_q;
	logic [63:0] bits_q, total_q;
	logic [5:0]  round_q;
	logic [3:0]  pad_q;      // 0: marker, 1: zeros, 2..9: length bytes
	logic        fin_q;
	logic [2:0]  idx_q;
	logic [31:0] cv [8];
	core_ctrl_t  ctrl;
	logic        iv_load;
	logic        acc, out_acc;
	logic [2:0]  nb;
	logic [7:0]  pb;
	logic        pbv;

	assign acc = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;
	assign nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

	// Pad byte selection for the current padding step.
	always_comb begin
		pb = 8'h00;
		pbv = 1'b1;
		if (pad_q == 4'd0) pb = PAD_BYTE;
		else if (pad_q == 4'd1) pbv = (fill_q != 6'd56);
		else pb = total_q[63 - 8*(pad_q - 4'd2) -: 8];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc) begin
				if ({1'b0, fill_q[1:0]} + nb > 3'd3 && fill_q[5:2] == 4'hf
					&& ({3'b0, fill_q} + {4'b0, nb}) >= 9'd64) state_d = ST_LOAD;
				else if (end_of_message) state_d = ST_PAD;
			end
			ST_PAD: if (pbv && fill_q == 6'd63) state_d = ST_LOAD;
				else if (pad_q == 4'd9) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_COMP;
			ST_COMP: if (round_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: state_d = (fin_q && pad_q == 4'd10) ? ST_OUT
				: (fin_q ? ST_PAD : ST_IDLE);
			ST_OUT: if (out_acc && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		ctrl.start = (state_q == ST_LOAD);
		ctrl.round = round_q;
		ctrl.fold = (state_q == ST_FOLD);
		iv_load = out_acc && idx_q == 3'd7;
	end

	// Byte insertion: a word is cleared when its first byte lands. Bytes that run
	// past the end of a full block wait in the spill word and enter word 0 at the
	// load cycle, after the core has taken the block.
	always_comb begin
		buf_d = buf_q;
		spill_d = spill_q;
		pos = '0;
		if (acc) begin
			for (int i = 0; i < 4; i++) begin
				pos = {1'b0, fill_q} + 7'(i);
				if (3'(i) < nb) begin
					if (pos[6]) begin
						if (pos[1:0] == 2'd0)
							spill_d = {message_word[31-8*i -: 8], 24'h0};
						else
							spill_d[31-8*pos[1:0] -: 8] = message_word[31-8*i -: 8];
					end else if (pos[1:0] == 2'd0)
						buf_d[pos[5:2]] = {message_word[31-8*i -: 8], 24'h0};
					else
						buf_d[pos[5:2]][31-8*pos[1:0] -: 8] = message_word[31-8*i -: 8];
				end
			end
		end else if (state_q == ST_PAD && pbv) begin
			if (fill_q[1:0] == 2'd0) buf_d[fill_q[5:2]] = {pb, 24'h0};
			else buf_d[fill_q[5:2]][31-8*fill_q[1:0] -: 8] = pb;
		end else if (state_q == ST_LOAD && fill_q != 6'd0) begin
			buf_d[0] = spill_q;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		spill_q <= spill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			total_q <= '0;
			round_q <= '0;
			pad_q <= '0;
			fin_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				fill_q <= 6'({1'b0, fill_q} + {4'b0, nb});
				bits_q <= bits_q + {58'b0, nb, 3'b0};
				total_q <= bits_q + {58'b0, nb, 3'b0};
				fin_q <= end_of_message;
				pad_q <= '0;
				round_q <= '0;
			end
			if (state_q == ST_PAD) begin
				if (pbv) fill_q <= fill_q + 6'd1;
				if (pad_q != 4'd1 || !pbv || fill_q == 6'd55) pad_q <= pad_q + 4'd1;
				round_q <= '0;
			end
			if (state_q == ST_COMP) round_q <= round_q + 6'd1;
			if (out_acc) idx_q <= idx_q + 3'd1;
			if (iv_load) begin
				fill_q <= '0;
				bits_q <= '0;
				fin_q <= 1'b0;
			end
		end
	end

	sm3_core u_core (
		.clk(clk), .arst_n(arst_n),
		.ctrl(ctrl),
		.iv_load(iv_load), .blk(buf_q), .cv(cv)
	);

	assign digest_word = cv[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_out_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fin_q) else $error("output without final word");
	a_round_rst: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_COMP) |-> round_q == 6'd0) else $error("round count");
`endif

endmodule

// ----- dv/sm3_hash_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash checker
// Watches both channels of the engine, keeps its own SM3 state, predicts the
// eight digest beats of every message and compares them as they come out.
// ----------------------------------------------------------------------------
module sm3_hash_checker import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_beats
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic [31:0] cv [8];
	logic [31:0] blk [16];
	int unsigned fill;
	logic [63:0] bit_len;
	digest_beat_t digest_q [$];

	function automatic logic [31:0] rl(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} << (n % 32);
		return d[63:32];
	endfunction

	task automatic compress();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 68; j++) begin
			if (j < 16)
				w[j] = blk[j];
			else begin
				t = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
				w[j] = t ^ rl(t, 15) ^ rl(t, 23) ^ rl(w[j-13], 7) ^ w[j-6];
			end
		end
		a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
		e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
		for (int j = 0; j < 64; j++) begin
			t = (j < 16) ? T_LOW : T_HIGH;
			a12 = rl(a, 12);
			ss1 = rl(a12 + e + rl(t, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + h + ss1 + w[j];
			d = c; c = rl(b, 9); b = a; a = tt1;
			h = g; g = rl(f, 19); f = e;
			e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
		end
		cv[0] ^= a; cv[1] ^= b; cv[2] ^= c; cv[3] ^= d;
		cv[4] ^= e; cv[5] ^= f; cv[6] ^= g; cv[7] ^= h;
	endtask

	task automatic append_byte(input logic [7:0] v);
		int sh;
		sh = 24 - 8 * (fill % 4);
		if (fill % 4 == 0)
			blk[fill / 4] = 32'(v) << sh;
		else
			blk[fill / 4] |= 32'(v) << sh;
		fill++;
		if (fill == 64) begin
			compress();
			fill = 0;
		end
	endtask

	task automatic absorb_word(input logic [31:0] wd, input logic [2:0] nb, input logic fin);
		int n;
		logic [63:0] total;
		n = (nb > 4) ? 4 : int'(nb);
		for (int i = 0; i < n; i++) begin
			append_byte(wd[31 - 8*i -: 8]);
			bit_len += 64'd8;
		end
		if (fin) begin
			total = bit_len;
			append_byte(PAD_BYTE);
			while (fill != 56)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(total[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++)
				digest_q.push_back('{cv[i], 3'(i), i == 7});
			cv = IV;
			fill = 0;
			bit_len = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			cv = IV;
			fill = 0;
			bit_len = '0;
			fail_count = 0;
			digest_q.delete();
		end else begin
			if (in_valid && in_ready)
				absorb_word(message_word, valid_bytes, end_of_message);
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest beat word=%h index=%0d last=%0b",
						$time, digest_word, word_index, last_word);
					fail_count++;
				end else begin
					exp_beat = digest_q.pop_front();
					if (exp_beat.word !== digest_word || exp_beat.index !== word_index ||
							exp_beat.last !== last_word) begin
						$display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
							$time, exp_beat.word, exp_beat.index, exp_beat.last,
							digest_word, word_index, last_word);
						fail_count++;
					end
				end
			end
		end
		pending_beats = digest_q.size();
	end

endmodule

// ----- dv/sm3_hash_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Drives directed and random messages into the engine with random gaps and
// stalls, including one long output hold-off, and reports the checker verdict.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] message_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          pending_beats;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;
	bit          hold_off = 1'b0;

	localparam int QUIET_LIMIT = 20000;

	always #5 clk = ~clk;

	sm3_hash_engine_top dut (.*);

	sm3_hash_checker checker_i (.*);

	// Watchdog on cycles with no accepted beat on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(99) >= 20);
	end

	// Called at a falling edge; valid stays high from one beat to the next
	// unless an idle cycle is drawn.
	task automatic send_word(input logic [31:0] wd, input logic [2:0] nb, input logic fin);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		message_word <= wd;
		valid_bytes <= nb;
		end_of_message <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random message: mostly full words, a random tail, sometimes stray partials.
	task automatic send_message(input int words);
		logic [2:0] nb;
		for (int i = 0; i < words; i++) begin
			nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
			send_word($urandom, nb, 1'b0);
		end
		send_word($urandom, 3'($urandom_range(7)), 1'b1);
	endtask

	initial begin
		int sent;
		int len;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty message, "abc", and odd byte counts.
		send_word(32'hdeadbeef, 3'd0, 1'b1);
		send_word(32'h61626300, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd7, 1'b0);
		send_word(32'h00000000, 3'd5, 1'b0);
		send_word(32'hffffffff, 3'd1, 1'b0);
		send_word(32'h12345678, 3'd6, 1'b1);
		// Exactly one block.
		for (int i = 0; i < 15; i++)
			send_word(32'h61626364, 3'd4, 1'b0);
		send_word(32'h61626364, 3'd4, 1'b1);
		sent = 22;

		calm = 1'b1;
		for (int i = 0; i < 3; i++)
			send_message(13);
		calm = 1'b0;

		// Keep the output blocked while input keeps coming in.
		hold_off = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 3; i++)
				send_message(5);
		join
		sent += 60;

		while (sent < 410) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(16);
			send_message(len);
			sent += len + 1;
		end
		in_valid <= 1'b0;

		while (pending_beats != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
